@@ hw/rtl/dhd_pkg.sv @@
// ----------------------------------------------------------------------------
// dhd_pkg
// shared types, constants and helper functions for the dataset header decoder
// ----------------------------------------------------------------------------
package dhd_pkg;

    // parse phases, in the order the optional fields follow the flag byte
    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_FLAG2  = 3'd1,
        PH_SEQ    = 3'd2,
        PH_TIME   = 3'd3,
        PH_PICO   = 3'd4,
        PH_STATUS = 3'd5,
        PH_MAJOR  = 3'd6,
        PH_MINOR  = 3'd7
    } phase_t;

    // presence flag bit positions
    localparam int FL_SEQ    = 0;
    localparam int FL_TIME   = 1;
    localparam int FL_STATUS = 2;
    localparam int FL_MAJOR  = 3;
    localparam int FL_MINOR  = 4;
    localparam int FL_FLAG2  = 5;
    localparam int FL_PICO   = 6;

    localparam int FLAGS_W   = 7;
    localparam int IDX_W     = 3;
    localparam int COUNT_W   = 5;

    // second flag byte layout
    localparam int F2_TYPE_W   = 4;
    localparam int F2_PICO_BIT = 4;

    // result packing, lowest field first, padded to whole bytes
    localparam int RESULT_BITS = 2 + 4 + FLAGS_W + 16 + 64 + 16 + 16 + 32 + 32 + COUNT_W;
    localparam int RESULT_W    = ((RESULT_BITS + 7) / 8) * 8;
    localparam int PAD_W       = RESULT_W - RESULT_BITS;

    // one classified byte handed from front to back
    typedef struct packed {
        logic [7:0]       data;
        logic             is_start;
        phase_t           phase;
        logic [IDX_W-1:0] idx;
        logic             last;
    } cmd_t;

    // bytes in each field
    function automatic logic [3:0] field_len(input phase_t ph);
        logic [3:0] len;
        unique case (ph)
            PH_FLAG2:  len = 4'd1;
            PH_SEQ:    len = 4'd2;
            PH_TIME:   len = 4'd8;
            PH_PICO:   len = 4'd2;
            PH_STATUS: len = 4'd2;
            PH_MAJOR:  len = 4'd4;
            PH_MINOR:  len = 4'd4;
            default:   len = 4'd0;
        endcase
        return len;
    endfunction

    // whether a phase's field is announced by the flags
    function automatic logic phase_present(input phase_t ph, input logic [FLAGS_W-1:0] flags);
        logic hit;
        unique case (ph)
            PH_FLAG2:  hit = flags[FL_FLAG2];
            PH_SEQ:    hit = flags[FL_SEQ];
            PH_TIME:   hit = flags[FL_TIME];
            PH_PICO:   hit = flags[FL_PICO];
            PH_STATUS: hit = flags[FL_STATUS];
            PH_MAJOR:  hit = flags[FL_MAJOR];
            PH_MINOR:  hit = flags[FL_MINOR];
            default:   hit = 1'b0;
        endcase
        return hit;
    endfunction

    // first announced phase after the given one, idle if none
    function automatic phase_t next_phase(input phase_t from, input logic [FLAGS_W-1:0] flags);
        phase_t res;
        logic   found;
        phase_t cand;
        res   = PH_IDLE;
        found = 1'b0;
        for (int q = 1; q < 8; q++) begin
            cand = phase_t'(3'(q));
            if (!found && (cand > from) && phase_present(cand, flags)) begin
                res   = cand;
                found = 1'b1;
            end
        end
        return res;
    endfunction

endpackage

@@ hw/rtl/dhd_front.sv @@
// ----------------------------------------------------------------------------
// dhd_front
// byte classifier: tracks header phase and tags each byte with its place
// ----------------------------------------------------------------------------
module dhd_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_fire,
    input  logic [7:0]    in_data,
    input  logic          in_start,
    output logic          push,
    output dhd_pkg::cmd_t push_cmd
);
    import dhd_pkg::*;

    phase_t               phase_reg, phase_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [FLAGS_W-1:0]   flags_reg, flags_next;
    phase_t               np;
    logic [3:0]           idx_inc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            idx_reg   <= '0;
            flags_reg <= '0;
        end else begin
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
            flags_reg <= flags_next;
        end
    end

    always_comb begin
        phase_next = phase_reg;
        idx_next   = idx_reg;
        flags_next = flags_reg;
        push       = 1'b0;
        np         = PH_IDLE;
        idx_inc    = {1'b0, idx_reg} + 4'd1;
        push_cmd.data     = in_data;
        push_cmd.is_start = in_start;
        push_cmd.phase    = phase_reg;
        push_cmd.idx      = idx_reg;
        push_cmd.last     = 1'b0;
        if (in_fire) begin
            if (in_start) begin
                // first flag byte: fresh header, old one dropped
                flags_next     = {1'b0, in_data[7:2]};
                np             = next_phase(PH_IDLE, flags_next);
                phase_next     = np;
                idx_next       = '0;
                push           = 1'b1;
                push_cmd.phase = PH_IDLE;
                push_cmd.idx   = '0;
                push_cmd.last  = (np == PH_IDLE);
            end else if (phase_reg != PH_IDLE) begin
                push = 1'b1;
                if (phase_reg == PH_FLAG2 && in_data[F2_PICO_BIT]) begin
                    flags_next[FL_PICO] = 1'b1;
                end
                if (idx_inc >= field_len(phase_reg)) begin
                    np            = next_phase(phase_reg, flags_next);
                    phase_next    = np;
                    idx_next      = '0;
                    push_cmd.last = (np == PH_IDLE);
                end else begin
                    idx_next = idx_inc[IDX_W-1:0];
                end
            end
            // bytes outside a header are dropped
        end
    end

endmodule

@@ hw/rtl/dhd_queue.sv @@
// ----------------------------------------------------------------------------
// dhd_queue
// two-entry fifo of classified bytes between front and back
// ----------------------------------------------------------------------------
module dhd_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  dhd_pkg::cmd_t push_cmd,
    output logic          full,
    output logic          pop_valid,
    output dhd_pkg::cmd_t pop_cmd,
    input  logic          pop
);
    import dhd_pkg::*;

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign full      = (count_reg == 2'd2);
    assign pop_valid = (count_reg != 2'd0);
    assign pop_cmd   = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    always_comb begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

@@ hw/rtl/dhd_back.sv @@
// ----------------------------------------------------------------------------
// dhd_back
// field capture and result register
// ----------------------------------------------------------------------------
module dhd_back (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cmd_valid,
    input  dhd_pkg::cmd_t                cmd,
    output logic                         cmd_pop,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [dhd_pkg::RESULT_W-1:0] m_tdata
);
    import dhd_pkg::*;

    logic [1:0]          enc_reg, enc_next;
    logic [3:0]          type_reg, type_next;
    logic [FLAGS_W-1:0]  flags_reg, flags_next;
    logic [15:0]         seq_reg, seq_next;
    logic [63:0]         time_reg, time_next;
    logic [15:0]         pico_reg, pico_next;
    logic [15:0]         status_reg, status_next;
    logic [31:0]         major_reg, major_next;
    logic [31:0]         minor_reg, minor_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic                valid_reg, valid_next;
    logic [RESULT_W-1:0] data_reg, data_next;
    logic                slot_free;

    // a closing byte waits until the result register can take it
    assign slot_free = !valid_reg || m_tready;
    assign cmd_pop   = cmd_valid && (!cmd.last || slot_free);
    assign m_tvalid  = valid_reg;
    assign m_tdata   = data_reg;

    always_comb begin
        enc_next    = enc_reg;
        type_next   = type_reg;
        flags_next  = flags_reg;
        seq_next    = seq_reg;
        time_next   = time_reg;
        pico_next   = pico_reg;
        status_next = status_reg;
        major_next  = major_reg;
        minor_next  = minor_reg;
        count_next  = count_reg;
        if (cmd.is_start) begin
            enc_next    = cmd.data[1:0];
            type_next   = '0;
            flags_next  = {1'b0, cmd.data[7:2]};
            seq_next    = '0;
            time_next   = '0;
            pico_next   = '0;
            status_next = '0;
            major_next  = '0;
            minor_next  = '0;
            count_next  = COUNT_W'(1);
        end else begin
            count_next = count_reg + COUNT_W'(1);
            unique case (cmd.phase)
                PH_FLAG2: begin
                    type_next = cmd.data[F2_TYPE_W-1:0];
                    if (cmd.data[F2_PICO_BIT]) begin
                        flags_next[FL_PICO] = 1'b1;
                    end
                end
                PH_SEQ:    seq_next[{cmd.idx[0], 3'b000} +: 8]      = cmd.data;
                PH_TIME:   time_next[{cmd.idx, 3'b000} +: 8]        = cmd.data;
                PH_PICO:   pico_next[{cmd.idx[0], 3'b000} +: 8]     = cmd.data;
                PH_STATUS: status_next[{cmd.idx[0], 3'b000} +: 8]   = cmd.data;
                PH_MAJOR:  major_next[{cmd.idx[1:0], 3'b000} +: 8]  = cmd.data;
                PH_MINOR:  minor_next[{cmd.idx[1:0], 3'b000} +: 8]  = cmd.data;
                default: ;
            endcase
        end
    end

    always_comb begin
        valid_next = valid_reg && !m_tready;
        data_next  = data_reg;
        if (cmd_pop && cmd.last) begin
            valid_next = 1'b1;
            data_next  = {{PAD_W{1'b0}}, count_next, minor_next, major_next, status_next,
                          pico_next, time_next, seq_next, flags_next, type_next, enc_next};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        if (cmd_pop) begin
            enc_reg    <= enc_next;
            type_reg   <= type_next;
            flags_reg  <= flags_next;
            seq_reg    <= seq_next;
            time_reg   <= time_next;
            pico_reg   <= pico_next;
            status_reg <= status_next;
            major_reg  <= major_next;
            minor_reg  <= minor_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ hw/rtl/dataset_header_decoder_core.sv @@
// ----------------------------------------------------------------------------
// dataset_header_decoder_core
// byte-serial decoder for publish/subscribe dataset message headers
// ----------------------------------------------------------------------------
// usage
//   s_ channel: one header byte per request in s_tdata, s_tuser marks the
//   first flag byte of a new header; bytes outside a header are dropped
//   m_ channel: one request per complete header carrying every decoded
//   field, the presence flags and the header length (1 to 24 bytes)
//   throughput: one byte per cycle while s_tready is high, with no gaps between headers
//   the result shows on m_tvalid once the closing byte has passed through
//   the byte queue and has been loaded into the result register
//   a start byte mid-header drops the unfinished header without a result
//   reset (aresetn low, synchronous) empties the queue and the result
//   register and returns the parser to idle
//   receiver stall: the result register holds; later bytes keep flowing
//   into the two-entry queue, and s_tready falls only when a second result
//   is ready behind a stalled one and the queue has filled
// ----------------------------------------------------------------------------
module dataset_header_decoder_core (
    input  logic                         aclk,
    input  logic                         aresetn,
    // slave side: header bytes
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   s_tdata,   // data_byte
    input  logic [0:0]                   s_tuser,   // start_req
    // master side: decoded headers
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // field_encoding[1:0], message_type[5:2], present_flags[12:6],
    // sequence_number[28:13], timestamp[92:29], picoseconds[108:93],
    // status_code[124:109], major_version[156:125], minor_version[188:157],
    // header_length[193:189], zero pad above
    output logic [dhd_pkg::RESULT_W-1:0] m_tdata
);
    import dhd_pkg::*;

    logic in_fire;
    logic push;
    cmd_t push_cmd;
    logic full;
    logic pop_valid;
    cmd_t pop_cmd;
    logic pop;

    // take a byte whenever the queue has room
    assign s_tready = !full;
    assign in_fire  = s_tvalid && s_tready;

    // front: tracks phase and flags, tags each byte with its field slot
    dhd_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_fire  (in_fire),
        .in_data  (s_tdata),
        .in_start (s_tuser[0]),
        .push     (push),
        .push_cmd (push_cmd)
    );

    // short queue decoupling the classifier from the capture stage
    dhd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (full),
        .pop_valid (pop_valid),
        .pop_cmd   (pop_cmd),
        .pop       (pop)
    );

    // back: captures field bytes and loads the result register
    dhd_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (pop_valid),
        .cmd       (pop_cmd),
        .cmd_pop   (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
